@@ rtl/core/mwcr_pkg.sv @@
// shared types and constants for the mip wavetable cubic reader
// field layout of the stream items, opcodes and sequencer states
// no dependencies
package mwcr_pkg;

	// sample word format, signed q3.20
	localparam int SAMPLE_W = 24;
	localparam int LIMIT_W  = 32;
	localparam int PHASE_W  = 32;
	localparam int FRAC_W   = 16;
	localparam int ACC_W    = 32;
	localparam int CFG_W    = 4;

	// input item layout in s_tdata, lowest bit first
	localparam int LEVEL_W   = 3;
	localparam int ENTRY_W   = 11;
	localparam int LEVEL_LSB = 0;
	localparam int ENTRY_LSB = 3;
	localparam int VALUE_LSB = 14;
	localparam int LIMIT_LSB = 38;
	localparam int PHASE_LSB = 70;
	localparam int STEP_LSB  = 102;
	localparam int S_TDATA_W = 136;
	localparam int S_TUSER_W = 2;

	// saturation bounds of q3.20
	localparam logic signed [ACC_W-1:0] SAT_MAX = 32'sd8388607;
	localparam logic signed [ACC_W-1:0] SAT_MIN = -32'sd8388608;

	typedef enum logic [S_TUSER_W-1:0] {
		OP_WRITE_WORD  = 2'd0,
		OP_WRITE_LIMIT = 2'd1,
		OP_SAMPLE      = 2'd2,
		OP_NONE        = 2'd3
	} opcode_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_SEARCH = 8'b0000_0010,
		ST_INDEX  = 8'b0000_0100,
		ST_READ   = 8'b0000_1000,
		ST_COEF   = 8'b0001_0000,
		ST_MUL    = 8'b0010_0000,
		ST_SAT    = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

endpackage

@@ rtl/core/mwcr_wave_ram.sv @@
// single-port table memory holding all mip levels back to back
// one write or one registered read per cycle
// depends on mwcr_pkg for the word width
module mwcr_wave_ram #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [AW-1:0]                        addr,
	input  logic signed [mwcr_pkg::SAMPLE_W-1:0] wdata,
	output logic signed [mwcr_pkg::SAMPLE_W-1:0] rdata
);

	logic signed [mwcr_pkg::SAMPLE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else begin
			rdata <= mem_q[addr];
		end
	end

endmodule

@@ rtl/core/mip_wavetable_cubic_reader_core.sv @@
// mip wavetable oscillator with catmull-rom interpolation, top level
// sequencer, level search, shared multiplier and output register
// depends on mwcr_pkg and mwcr_wave_ram
//
// usage
//   s_* channel: one item per handshake; s_tuser holds the opcode
//     (table word write, level limit write, sample request)
//   m_* channel: one item per sample request: interpolated value and clip flag
//   cfg_* channel: levels_in_use, always ready, write only while the block is idle
// timing
//   writes leave the block idle, so it is ready again on the next cycle
//   a sample passes the search, index, read, coef, mul, sat and done states before
//   m_tvalid, searching 1 to levels_in_use levels; straight to done if none in use
//   the level search does one limit compare per cycle, the four neighbor words
//   come one per cycle from the single-port table memory, and the three
//   horner steps run one after another on one 33x18 multiplier
// reset
//   arst_n clears the sequencer, the output valid and levels_in_use; table
//   words and level limits hold garbage until written
// stall
//   the result waits in the output register; a new item is taken meanwhile,
//   and a following sample holds in its last state until the register frees
module mip_wavetable_cubic_reader_core #(
	parameter int TABLE_DEPTH = 2048,
	parameter int LEVEL_COUNT = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// level[2:0], entry[13:3], sample_value[37:14], level_limit[69:38],
	// phase[101:70], phase_step[133:102], zero fill[135:134]
	input  logic [mwcr_pkg::S_TDATA_W-1:0]    s_tdata,
	// opcode[1:0]
	input  logic [mwcr_pkg::S_TUSER_W-1:0]    s_tuser,
	// result items
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// sample_out[23:0]
	output logic [mwcr_pkg::SAMPLE_W-1:0]     m_tdata,
	// clipped[0]
	output logic [0:0]                        m_tuser,
	// levels_in_use register
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mwcr_pkg::CFG_W-1:0]        cfg_data
);

	// table index width, level index width, memory size
	localparam int IW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LW        = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
	localparam int MEM_DEPTH = LEVEL_COUNT * TABLE_DEPTH;
	localparam int MAW       = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int NW        = 5;     // holds a level count up to 16
	localparam int EW        = 17;    // holds an entry compare up to 65536
	localparam int MA_W      = 33;
	localparam int MB_W      = 18;
	localparam int MP_W      = MA_W + MB_W;

	localparam int SW = mwcr_pkg::SAMPLE_W;
	localparam int AC = mwcr_pkg::ACC_W;
	localparam int FW = mwcr_pkg::FRAC_W;

	// ---------------------------------------------------------------
	// input field unpacking
	// ---------------------------------------------------------------
	mwcr_pkg::opcode_t                   in_op;
	logic [mwcr_pkg::LEVEL_W-1:0]        in_level;
	logic [mwcr_pkg::ENTRY_W-1:0]        in_entry;
	logic signed [SW-1:0]                in_value;
	logic [mwcr_pkg::LIMIT_W-1:0]        in_limit;
	logic [mwcr_pkg::PHASE_W-1:0]        in_phase;
	logic [mwcr_pkg::PHASE_W-1:0]        in_step;

	assign in_op    = mwcr_pkg::opcode_t'(s_tuser);
	assign in_level = s_tdata[mwcr_pkg::LEVEL_LSB +: mwcr_pkg::LEVEL_W];
	assign in_entry = s_tdata[mwcr_pkg::ENTRY_LSB +: mwcr_pkg::ENTRY_W];
	assign in_value = s_tdata[mwcr_pkg::VALUE_LSB +: SW];
	assign in_limit = s_tdata[mwcr_pkg::LIMIT_LSB +: mwcr_pkg::LIMIT_W];
	assign in_phase = s_tdata[mwcr_pkg::PHASE_LSB +: mwcr_pkg::PHASE_W];
	assign in_step  = s_tdata[mwcr_pkg::STEP_LSB +: mwcr_pkg::PHASE_W];

	// ---------------------------------------------------------------
	// registers
	// ---------------------------------------------------------------
	mwcr_pkg::state_t                    state_q;
	logic [mwcr_pkg::CFG_W-1:0]          levels_q;
	logic [NW-1:0]                       n_q;         // levels in use, latched per sample
	logic [LW-1:0]                       srch_q;      // level under compare
	logic [LW-1:0]                       lvl_q;       // chosen level
	logic [2:0]                          rd_q;        // neighbor read step, 0..4
	logic [1:0]                          mul_cnt_q;   // horner step, 0..2
	logic [mwcr_pkg::PHASE_W-1:0]        phase_q;
	logic [mwcr_pkg::PHASE_W-1:0]        step_q;
	logic [IW-1:0]                       idx_q;
	logic [FW-1:0]                       frac_q;
	logic signed [SW-1:0]                y_q [4];     // y0..y3 after four shifts
	logic signed [AC-1:0]                acc_q;
	logic signed [AC-1:0]                b_q;
	logic signed [AC-1:0]                c_q;
	logic signed [SW-1:0]                res_q;
	logic                                clip_q;
	logic                                m_tvalid_q;
	logic [SW-1:0]                       m_tdata_q;
	logic                                m_tuser_q;
	logic [mwcr_pkg::LIMIT_W-1:0]        limit_q [LEVEL_COUNT];

	// ---------------------------------------------------------------
	// handshakes
	// ---------------------------------------------------------------
	logic in_acc;
	logic out_free;
	logic [NW-1:0] n_eff;

	assign s_tready  = (state_q == mwcr_pkg::ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	// register above the level count acts as the level count
	assign n_eff = (NW'(levels_q) > NW'(LEVEL_COUNT)) ? NW'(LEVEL_COUNT) : NW'(levels_q);

	// range checks on writes
	logic lvl_ok;
	logic entry_ok;
	assign lvl_ok   = NW'(in_level) < NW'(LEVEL_COUNT);
	assign entry_ok = EW'(in_entry) < EW'(TABLE_DEPTH);

	// ---------------------------------------------------------------
	// shared multiplier: phase scaling, then the three horner steps
	// ---------------------------------------------------------------
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [MP_W-1:0] prod;

	always_comb begin
		if (state_q == mwcr_pkg::ST_INDEX) begin
			mul_a = {1'b0, phase_q};
			mul_b = MB_W'(TABLE_DEPTH);
		end else begin
			mul_a = {acc_q[AC-1], acc_q};
			mul_b = {2'b00, frac_q};
		end
	end

	assign prod = mul_a * mul_b;

	// floor(acc * f / 2^16) plus the addend of this step
	logic signed [AC-1:0] addend;
	logic signed [AC-1:0] y1_ext;
	logic signed [AC-1:0] acc_next;

	assign y1_ext = {{(AC-SW){y_q[1][SW-1]}}, y_q[1]};

	always_comb begin
		case (mul_cnt_q)
			2'd0:    addend = b_q;
			2'd1:    addend = c_q;
			default: addend = y1_ext <<< 1;
		endcase
	end

	assign acc_next = prod[FW +: AC] + addend;

	// ---------------------------------------------------------------
	// doubled catmull-rom coefficients from the four neighbor words
	// ---------------------------------------------------------------
	logic signed [AC-1:0] y0e, y2e, y3e;
	logic signed [AC-1:0] coef_a, coef_b, coef_c;

	assign y0e = {{(AC-SW){y_q[0][SW-1]}}, y_q[0]};
	assign y2e = {{(AC-SW){y_q[2][SW-1]}}, y_q[2]};
	assign y3e = {{(AC-SW){y_q[3][SW-1]}}, y_q[3]};

	assign coef_a = y3e - y0e + 32'sd3 * (y1_ext - y2e);
	assign coef_b = (y0e <<< 1) - 32'sd5 * y1_ext + (y2e <<< 2) - y3e;
	assign coef_c = y2e - y0e;

	// ---------------------------------------------------------------
	// rounding and saturation
	// ---------------------------------------------------------------
	logic signed [AC:0]   round_sum;
	logic signed [AC-1:0] rounded;
	logic                 over_hi;
	logic                 over_lo;

	assign round_sum = {acc_q[AC-1], acc_q} + 33'sd1;
	assign rounded   = round_sum[AC:1];
	assign over_hi   = rounded > mwcr_pkg::SAT_MAX;
	assign over_lo   = rounded < mwcr_pkg::SAT_MIN;

	// ---------------------------------------------------------------
	// neighbor position with wrap-around, one per read step
	// ---------------------------------------------------------------
	logic [IW-1:0] rd_pos;
	logic [IW:0]   pos_p2;

	assign pos_p2 = (IW+1)'(idx_q) + (IW+1)'(2);

	always_comb begin
		case (rd_q[1:0])
			2'd0:    rd_pos = (idx_q == '0) ? IW'(TABLE_DEPTH - 1) : idx_q - IW'(1);
			2'd1:    rd_pos = idx_q;
			2'd2:    rd_pos = (idx_q == IW'(TABLE_DEPTH - 1)) ? '0 : idx_q + IW'(1);
			default: rd_pos = (pos_p2 >= (IW+1)'(TABLE_DEPTH)) ?
				IW'(pos_p2 - (IW+1)'(TABLE_DEPTH)) : IW'(pos_p2);
		endcase
	end

	// ---------------------------------------------------------------
	// table memory, levels laid out back to back
	// ---------------------------------------------------------------
	logic                 ram_we;
	logic [MAW-1:0]       ram_addr;
	logic [MAW-1:0]       wr_addr;
	logic [MAW-1:0]       rd_addr;
	logic signed [SW-1:0] ram_rdata;

	assign ram_we  = in_acc && (in_op == mwcr_pkg::OP_WRITE_WORD) && lvl_ok && entry_ok;
	assign wr_addr = MAW'(LW'(in_level)) * MAW'(TABLE_DEPTH) + MAW'(IW'(in_entry));
	assign rd_addr = MAW'(lvl_q) * MAW'(TABLE_DEPTH) + MAW'(rd_pos);
	assign ram_addr = (state_q == mwcr_pkg::ST_IDLE) ? wr_addr : rd_addr;

	mwcr_wave_ram #(
		.DEPTH (MEM_DEPTH),
		.AW    (MAW)
	) u_wave_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (in_value),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------
	// level limits, written by limit items, no reset
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_acc && (in_op == mwcr_pkg::OP_WRITE_LIMIT) && lvl_ok) begin
			limit_q[LW'(in_level)] <= in_limit;
		end
	end

	logic srch_hit;
	logic srch_last;
	assign srch_hit  = step_q <= limit_q[srch_q];
	assign srch_last = NW'(srch_q) == (n_q - NW'(1));

	// ---------------------------------------------------------------
	// configuration register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			levels_q <= cfg_data;
		end
	end

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mwcr_pkg::ST_IDLE;
			n_q       <= '0;
			srch_q    <= '0;
			lvl_q     <= '0;
			rd_q      <= '0;
			mul_cnt_q <= '0;
		end else begin
			case (state_q)
				mwcr_pkg::ST_IDLE: begin
					if (in_acc && (in_op == mwcr_pkg::OP_SAMPLE)) begin
						n_q    <= n_eff;
						srch_q <= '0;
						// no level in use: straight to the output with zero
						state_q <= (n_eff == '0) ? mwcr_pkg::ST_DONE : mwcr_pkg::ST_SEARCH;
					end
				end
				mwcr_pkg::ST_SEARCH: begin
					// first level whose limit covers the step, else the last one
					if (srch_hit || srch_last) begin
						lvl_q   <= srch_q;
						state_q <= mwcr_pkg::ST_INDEX;
					end else begin
						srch_q <= srch_q + LW'(1);
					end
				end
				mwcr_pkg::ST_INDEX: begin
					rd_q    <= '0;
					state_q <= mwcr_pkg::ST_READ;
				end
				mwcr_pkg::ST_READ: begin
					if (rd_q == 3'd4) begin
						state_q <= mwcr_pkg::ST_COEF;
					end
					rd_q <= rd_q + 3'd1;
				end
				mwcr_pkg::ST_COEF: begin
					mul_cnt_q <= '0;
					state_q   <= mwcr_pkg::ST_MUL;
				end
				mwcr_pkg::ST_MUL: begin
					if (mul_cnt_q == 2'd2) begin
						state_q <= mwcr_pkg::ST_SAT;
					end
					mul_cnt_q <= mul_cnt_q + 2'd1;
				end
				mwcr_pkg::ST_SAT: begin
					state_q <= mwcr_pkg::ST_DONE;
				end
				mwcr_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= mwcr_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= mwcr_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// datapath registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_acc && (in_op == mwcr_pkg::OP_SAMPLE)) begin
			phase_q <= in_phase;
			step_q  <= in_step;
			res_q   <= '0;
			clip_q  <= 1'b0;
		end
		// integer part of phase * depth sits above the 32 fraction bits
		if (state_q == mwcr_pkg::ST_INDEX) begin
			idx_q  <= prod[mwcr_pkg::PHASE_W +: IW];
			frac_q <= prod[FW +: FW];
		end
		// words come from the registered read of their address; shift them in
		if ((state_q == mwcr_pkg::ST_READ) && (rd_q != 3'd0)) begin
			y_q[3] <= ram_rdata;
			y_q[2] <= y_q[3];
			y_q[1] <= y_q[2];
			y_q[0] <= y_q[1];
		end
		if (state_q == mwcr_pkg::ST_COEF) begin
			acc_q <= coef_a;
			b_q   <= coef_b;
			c_q   <= coef_c;
		end
		if (state_q == mwcr_pkg::ST_MUL) begin
			acc_q <= acc_next;
		end
		if (state_q == mwcr_pkg::ST_SAT) begin
			clip_q <= over_hi || over_lo;
			if (over_hi) begin
				res_q <= SW'(mwcr_pkg::SAT_MAX);
			end else if (over_lo) begin
				res_q <= SW'(mwcr_pkg::SAT_MIN);
			end else begin
				res_q <= rounded[SW-1:0];
			end
		end
	end

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	logic out_load;
	assign out_load = (state_q == mwcr_pkg::ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= res_q;
			m_tuser_q <= clip_q;
		end
	end

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	// the search never walks past the last level in use
	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mwcr_pkg::ST_SEARCH) |-> (NW'(srch_q) < n_q))
		else $error("level search past last level in use");

	// the table memory is written only between samples
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == mwcr_pkg::ST_IDLE))
		else $error("table write during a sample");

	// saturation follows exactly three horner steps
	a_three_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mwcr_pkg::ST_SAT) |-> ($past(state_q) == mwcr_pkg::ST_MUL
			&& $past(mul_cnt_q) == 2'd2))
		else $error("rounding reached before third multiply");

	// a sample with no levels in use goes straight to the output stage
	a_no_level: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_op == mwcr_pkg::OP_SAMPLE) && (n_eff == '0))
			|=> (state_q == mwcr_pkg::ST_DONE))
		else $error("empty level set did not short-cut");

endmodule

@@ tb/tb_mip_wavetable_cubic_reader_core.sv @@
// testbench for mip_wavetable_cubic_reader_core: loads table words and level limits,
// requests interpolated samples and checks each one against a local fixed-point model
// depends on mwcr_pkg and the core rtl
module tb_mip_wavetable_cubic_reader_core;

	localparam int DEPTH       = 2048;
	localparam int LEVELS      = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT  = 5000;
	localparam logic [mwcr_pkg::SAMPLE_W-1:0] WORD_MAX = 24'h7FFFFF;
	localparam logic [mwcr_pkg::SAMPLE_W-1:0] WORD_MIN = 24'h800000;

	// one expected sample: interpolated value and clip flag
	typedef struct packed {
		logic [mwcr_pkg::SAMPLE_W-1:0] value;
		logic                          clip;
	} sample_res_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [mwcr_pkg::S_TDATA_W-1:0]  s_tdata;
	logic [mwcr_pkg::S_TUSER_W-1:0]  s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [mwcr_pkg::SAMPLE_W-1:0]   m_tdata;
	logic [0:0]                      m_tuser;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [mwcr_pkg::CFG_W-1:0]      cfg_data;

	mip_wavetable_cubic_reader_core #(
		.TABLE_DEPTH(DEPTH),
		.LEVEL_COUNT(LEVELS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// shadow of the block state: tables, written marks, limits and levels_in_use
	logic signed [mwcr_pkg::SAMPLE_W-1:0] wave_mem [LEVELS*DEPTH];
	bit                                   wave_set [LEVELS*DEPTH];
	logic [mwcr_pkg::LIMIT_W-1:0]         limit_mem [LEVELS];
	logic [mwcr_pkg::CFG_W-1:0]           level_cfg;
	// last index read per level, so later samples revisit loaded neighborhoods
	logic [mwcr_pkg::ENTRY_W-1:0]         anchor [LEVELS];

	sample_res_t sample_q [$];
	sample_res_t oldest;
	int          errors      = 0;
	bit          idle_on     = 1'b1;
	int          hold_asks   = 0;
	int          hold_served = 0;
	int          hold_left   = 0;
	int          stall_left  = 0;
	int          idle_cycles = 0;

	// gap length: none when idle_on is off, else mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [mwcr_pkg::SAMPLE_W-1:0] rand_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return WORD_MAX;
		if (r == 1)
			return WORD_MIN;
		return 24'($urandom);
	endfunction

	function automatic logic [mwcr_pkg::LIMIT_W-1:0] rand_limit();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	// phase step: random, at or next to a stored limit, or at the extremes
	function automatic logic [mwcr_pkg::PHASE_W-1:0] rand_step();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return $urandom;
		if (r < 8)
			return limit_mem[$urandom_range(0, LEVELS-1)] + 32'($urandom_range(0, 2)) - 32'd1;
		if (r == 8)
			return '0;
		return '1;
	endfunction

	// first level in use whose limit covers the step, else the last one; -1 when none
	function automatic int choose_level(input logic [mwcr_pkg::PHASE_W-1:0] step);
		int n;
		int i;
		n = (level_cfg > LEVELS) ? LEVELS : int'(level_cfg);
		if (n == 0)
			return -1;
		for (i = 0; i < n; i++) begin
			if (step <= limit_mem[i])
				return i;
		end
		return n - 1;
	endfunction

	function automatic longint word_at(input int lvl, input logic [mwcr_pkg::ENTRY_W-1:0] pos);
		return longint'(wave_mem[lvl*DEPTH + pos]);
	endfunction

	// catmull-rom in horner form on doubled coefficients, floor shifts, round half up
	function automatic sample_res_t predict_sample(input logic [mwcr_pkg::PHASE_W-1:0] phase,
			input logic [mwcr_pkg::PHASE_W-1:0] step);
		sample_res_t res;
		int lvl;
		logic [mwcr_pkg::ENTRY_W-1:0] idx;
		longint f, y0, y1, y2, y3, ca, cb, cc, h, r;
		res = '0;
		lvl = choose_level(step);
		if (lvl < 0)
			return res;
		// phase * 2048: index is the top 11 bits, the fraction the next 16
		idx = phase[31:21];
		f   = longint'(phase[20:5]);
		y0  = word_at(lvl, idx - 11'd1);
		y1  = word_at(lvl, idx);
		y2  = word_at(lvl, idx + 11'd1);
		y3  = word_at(lvl, idx + 11'd2);
		ca  = -y0 + 3 * y1 - 3 * y2 + y3;
		cb  = 2 * y0 - 5 * y1 + 4 * y2 - y3;
		cc  = y2 - y0;
		h   = ((ca * f) >>> 16) + cb;
		h   = ((h * f) >>> 16) + cc;
		h   = ((h * f) >>> 16) + 2 * y1;
		r   = (h + 1) >>> 1;
		if (r > 64'sd8388607) begin
			r = 64'sd8388607;
			res.clip = 1'b1;
		end else if (r < -64'sd8388608) begin
			r = -64'sd8388608;
			res.clip = 1'b1;
		end
		res.value = r[mwcr_pkg::SAMPLE_W-1:0];
		return res;
	endfunction

	// after an optional gap, offer one item, wait for the handshake, then update the shadow state
	task automatic send_item(input mwcr_pkg::opcode_t op,
			input logic [mwcr_pkg::LEVEL_W-1:0] lvl,
			input logic [mwcr_pkg::ENTRY_W-1:0] entry,
			input logic [mwcr_pkg::SAMPLE_W-1:0] value,
			input logic [mwcr_pkg::LIMIT_W-1:0] limit,
			input logic [mwcr_pkg::PHASE_W-1:0] phase,
			input logic [mwcr_pkg::PHASE_W-1:0] step);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, step, phase, limit, value, entry, lvl};
		do @(posedge clk); while (!s_tready);
		case (op)
			mwcr_pkg::OP_WRITE_WORD: begin
				wave_mem[int'({lvl, entry})] = value;
				wave_set[int'({lvl, entry})] = 1'b1;
			end
			mwcr_pkg::OP_WRITE_LIMIT: limit_mem[lvl] = limit;
			mwcr_pkg::OP_SAMPLE:      sample_q.push_back(predict_sample(phase, step));
			default: ;
		endcase
	endtask

	task automatic write_word(input logic [mwcr_pkg::LEVEL_W-1:0] lvl,
			input logic [mwcr_pkg::ENTRY_W-1:0] entry,
			input logic [mwcr_pkg::SAMPLE_W-1:0] value);
		send_item(mwcr_pkg::OP_WRITE_WORD, lvl, entry, value, $urandom, $urandom, $urandom);
	endtask

	task automatic write_limit(input logic [mwcr_pkg::LEVEL_W-1:0] lvl,
			input logic [mwcr_pkg::LIMIT_W-1:0] limit);
		send_item(mwcr_pkg::OP_WRITE_LIMIT, lvl, 11'($urandom), 24'($urandom), limit,
			$urandom, $urandom);
	endtask

	task automatic request_sample(input logic [mwcr_pkg::PHASE_W-1:0] phase,
			input logic [mwcr_pkg::PHASE_W-1:0] step);
		send_item(mwcr_pkg::OP_SAMPLE, 3'($urandom), 11'($urandom), 24'($urandom), $urandom,
			phase, step);
	endtask

	task automatic send_none();
		send_item(mwcr_pkg::OP_NONE, 3'($urandom), 11'($urandom), 24'($urandom), $urandom,
			$urandom, $urandom);
	endtask

	// sample request whose four neighbor words are loaded first if still unwritten
	task automatic play_sample(input logic [mwcr_pkg::PHASE_W-1:0] step);
		int lvl;
		int k;
		logic [mwcr_pkg::ENTRY_W-1:0] idx;
		logic [mwcr_pkg::ENTRY_W-1:0] pos;
		lvl = choose_level(step);
		idx = 11'($urandom);
		if (lvl >= 0) begin
			if ($urandom_range(0, 2) != 0)
				idx = anchor[lvl] + 11'($urandom_range(0, 6)) - 11'd3;
			for (k = -1; k <= 2; k++) begin
				pos = idx + 11'(k);
				if (!wave_set[lvl*DEPTH + pos])
					write_word(3'(lvl), pos, rand_word());
			end
			anchor[lvl] = idx;
		end
		request_sample({idx, 21'($urandom)}, step);
	endtask

	// levels_in_use is written only once every sample is out and writes have settled
	task automatic set_levels(input logic [mwcr_pkg::CFG_W-1:0] v);
		s_tvalid <= 1'b0;
		while (sample_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		level_cfg = v;
	endtask

	// no levels in use: every sample is zero, opcode 3 is dropped
	task automatic test_no_levels();
		set_levels(4'd0);
		request_sample(32'h0000_0000, 32'h0000_0000);
		request_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_none();
		request_sample(32'h8000_0000, 32'h0000_0001);
	endtask

	// ascending limits, zero at the bottom and all ones at the top
	task automatic test_level_limits();
		int i;
		for (i = 0; i < LEVELS; i++) begin
			if (i == 0)
				write_limit(3'(i), '0);
			else if (i == LEVELS - 1)
				write_limit(3'(i), '1);
			else
				write_limit(3'(i), 32'(i) * 32'h2000_0000);
		end
	endtask

	// reads across the table ends, fraction extremes, overshoot past both rails
	task automatic test_wrap_and_clip();
		set_levels(4'd8);
		write_word(3'd0, 11'd2046, WORD_MAX);
		write_word(3'd0, 11'd2047, WORD_MIN);
		write_word(3'd0, 11'd0, 24'h123456);
		write_word(3'd0, 11'd1, WORD_MAX);
		write_word(3'd0, 11'd2, WORD_MIN);
		// index 0 pulls its left neighbor from the table end
		request_sample({11'd0, 21'h000000}, 32'h0000_0000);
		// last index pulls two words from the table start, fraction all ones
		request_sample({11'h7FF, 21'h1FFFFF}, 32'h0000_0000);
		// low-high-high-low at half fraction overshoots the top rail
		write_word(3'd7, 11'd100, WORD_MIN);
		write_word(3'd7, 11'd101, WORD_MAX);
		write_word(3'd7, 11'd102, WORD_MAX);
		write_word(3'd7, 11'd103, WORD_MIN);
		request_sample({11'd101, 21'h100000}, 32'hFFFF_FFFF);
		// the mirror image undershoots the bottom rail; step equals level 6 limit
		write_word(3'd6, 11'd100, WORD_MAX);
		write_word(3'd6, 11'd101, WORD_MIN);
		write_word(3'd6, 11'd102, WORD_MIN);
		write_word(3'd6, 11'd103, WORD_MAX);
		request_sample({11'd101, 21'h100000}, 32'hC000_0000);
	endtask

	// mixed loads and samples under one levels_in_use setting
	task automatic test_random_traffic(input logic [mwcr_pkg::CFG_W-1:0] cfg, input int count,
			input bit idle);
		int k;
		int r;
		idle_on = idle;
		set_levels(cfg);
		for (k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				play_sample(rand_step());
			else if (r < 82)
				write_word(3'($urandom), 11'($urandom), rand_word());
			else if (r < 94)
				write_limit(3'($urandom), rand_limit());
			else
				send_none();
		end
		idle_on = 1'b1;
	endtask

	// receiver holds off while samples keep coming, so the block backs up its input
	task automatic test_backpressure();
		int k;
		idle_on = 1'b0;
		hold_asks++;
		for (k = 0; k < 20; k++)
			play_sample(rand_step());
		idle_on = 1'b1;
	endtask

	// result side: long hold on request, else random short and long stalls while idle_on is set
	always @(posedge clk) begin
		if (hold_asks != hold_served) begin
			hold_served = hold_asks;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// each result item against the oldest expected sample
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (sample_q.size() == 0) begin
				$display("%0t: unexpected result, sample_out %h clipped %b", $time, m_tdata,
					m_tuser);
				errors++;
			end else begin
				oldest = sample_q.pop_front();
				if (m_tdata !== oldest.value) begin
					$display("%0t: sample_out expected %h actual %h", $time, oldest.value,
						m_tdata);
					errors++;
				end
				if (m_tuser[0] !== oldest.clip) begin
					$display("%0t: clipped expected %b actual %b", $time, oldest.clip,
						m_tuser[0]);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("mip_wavetable_cubic_reader_core test failed");
			$finish;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= mwcr_pkg::OP_NONE;
		m_tready  <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		level_cfg = '0;
		foreach (anchor[i])
			anchor[i] = 11'($urandom);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_no_levels();
		test_level_limits();
		test_wrap_and_clip();
		// settings above the level count act as eight
		test_random_traffic(4'd8, 60, 1'b1);
		test_random_traffic(4'd3, 50, 1'b1);
		test_random_traffic(4'd15, 50, 1'b0);
		test_random_traffic(4'd1, 50, 1'b1);
		test_random_traffic(4'd0, 20, 1'b1);
		test_random_traffic(4'd9, 30, 1'b1);
		test_random_traffic(4'd5, 30, 1'b1);
		test_backpressure();

		s_tvalid <= 1'b0;
		while (sample_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("mip_wavetable_cubic_reader_core test passed");
		else
			$display("mip_wavetable_cubic_reader_core test failed");
		$finish;
	end

endmodule
